FILE: hdl/lki_pkg.sv
// Shared types and constants for the looping keyframe interpolator.
// Used by lki_ctrl, lki_dpath and looping_keyframe_interpolator.
package lki_pkg;

    localparam int MAX_KEYS  = 1024;
    localparam int KEY_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = KEY_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SMP_W     = 11;
    localparam int SUM_W     = DATA_W + 1;
    localparam int NOW_W     = DATA_W + SMP_W;
    localparam int NUM_TRK   = 3;
    localparam int TRK_W     = 2;

    localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

    // register byte addresses
    localparam logic [2:0] ADDR_DURATION = 3'd0;
    localparam logic [2:0] ADDR_SAMPLES  = 3'd4;

    // track numbers
    localparam logic [TRK_W-1:0] TRK_POS = 2'd0;
    localparam logic [TRK_W-1:0] TRK_ROT = 2'd1;
    localparam logic [TRK_W-1:0] TRK_SCL = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_POS  = 2'd1,
        OP_ROT  = 2'd2,
        OP_SCL  = 2'd3
    } op_t;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_MOD   = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_SCAN  = 11'b00000010000,
        S_TSET  = 11'b00000100000,
        S_DINIT = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_LMUL  = 11'b00100000000,
        S_LADD  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic             clr_wr;
        logic             key_wr;
        logic             tick_start;
        logic             mod_step;
        logic             mul_now;
        logic             scan_step;
        logic             track_setup;
        logic             div_init;
        logic             div_step;
        logic             lerp_mul;
        logic             lerp_add;
        logic             out_load;
        logic [CNT_W-1:0] cnt;
        logic [TRK_W-1:0] trk;
    } lki_cmd_t;

endpackage

FILE: hdl/lki_ctrl.sv
// Sequencer of the keyframe interpolator: clear pass, clock wrap, key scan,
// per-track ratio and blend, result hand-off. Depends on lki_pkg.
module lki_ctrl
    import lki_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [1:0]        op,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output lki_cmd_t          cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TRK_W-1:0] trk_reg, trk_next;
    logic             rv_reg, rv_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        trk_next   = trk_reg;
        rv_next    = rv_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        cmd.trk    = trk_reg;
        if (rv_reg && !result_stall)
        begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (cnt_reg == CNT_W'(MAX_KEYS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (op == OP_TICK)
                    begin
                        cmd.tick_start = 1'b1;
                        cnt_next       = '0;
                        state_next     = S_MOD;
                    end
                    else
                    begin
                        cmd.key_wr = 1'b1;
                    end
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                cmd.mul_now = 1'b1;
                cnt_next    = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (cnt_reg == CNT_W'(MAX_KEYS))
                begin
                    trk_next   = TRK_POS;
                    state_next = S_TSET;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TSET:
            begin
                cmd.track_setup = 1'b1;
                state_next      = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    state_next = S_LMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_LMUL:
            begin
                cmd.lerp_mul = 1'b1;
                state_next   = S_LADD;
            end
            S_LADD:
            begin
                cmd.lerp_add = 1'b1;
                if (trk_reg == TRK_SCL)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    trk_next   = trk_reg + 1'b1;
                    state_next = S_TSET;
                end
            end
            S_OUT:
            begin
                if (!rv_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    rv_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = rv_reg;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            trk_reg   <= TRK_POS;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            trk_reg   <= trk_next;
            rv_reg    <= rv_next;
        end
    end

endmodule

FILE: hdl/lki_dpath.sv
// Datapath of the keyframe interpolator: key memories, clock wrap unit,
// scan trackers, ratio divider and blend multipliers. Depends on lki_pkg.
module lki_dpath
    import lki_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lki_cmd_t                 cmd,
    input  logic [1:0]               op,
    input  logic [DATA_W-1:0]        time_step,
    input  logic [KEY_W-1:0]         key_index,
    input  logic signed [DATA_W-1:0] value_first,
    input  logic signed [DATA_W-1:0] value_second,
    input  logic [DATA_W-1:0]        loop_duration,
    input  logic [SMP_W-1:0]         sample_count,
    output logic signed [DATA_W-1:0] pos_x,
    output logic signed [DATA_W-1:0] pos_y,
    output logic signed [DATA_W-1:0] angle,
    output logic signed [DATA_W-1:0] scale_x,
    output logic signed [DATA_W-1:0] scale_y
);

    localparam int PAIR_W = 2 * DATA_W + 1;
    localparam int ROT_W  = DATA_W + 1;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic [DATA_W-1:0] dur_eff;
    logic [SMP_W-1:0]  smp_eff;

    // key memories: {valid, first, second}; rotation keeps {valid, first}
    logic [PAIR_W-1:0] pos_mem [MAX_KEYS];
    logic [ROT_W-1:0]  rot_mem [MAX_KEYS];
    logic [PAIR_W-1:0] scl_mem [MAX_KEYS];
    logic [PAIR_W-1:0] pos_rd_reg, scl_rd_reg;
    logic [ROT_W-1:0]  rot_rd_reg;
    logic [KEY_W-1:0]  wr_addr;
    logic              wr_first;
    logic [PAIR_W-1:0] pos_wr_data, scl_wr_data;
    logic [ROT_W-1:0]  rot_wr_data;

    // clock and scan
    logic [SUM_W-1:0]  sum_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] clock_reg;
    logic [SUM_W-1:0]  mod_sh;
    logic [NOW_W-1:0]  now_reg;
    logic [NOW_W-1:0]  kd_reg;
    logic [KEY_W-1:0]  scan_key;

    logic                     rd_vld [NUM_TRK];
    logic signed [DATA_W-1:0] rd_v0  [NUM_TRK];
    logic signed [DATA_W-1:0] rd_v1  [NUM_TRK];

    logic                     found_reg [NUM_TRK];
    logic [KEY_W-1:0]         lk_reg    [NUM_TRK];
    logic [KEY_W-1:0]         nk_reg    [NUM_TRK];
    logic signed [DATA_W-1:0] a0_reg    [NUM_TRK];
    logic signed [DATA_W-1:0] a1_reg    [NUM_TRK];
    logic signed [DATA_W-1:0] b0_reg    [NUM_TRK];
    logic signed [DATA_W-1:0] b1_reg    [NUM_TRK];

    // ratio
    logic [SMP_W-1:0]     span;
    logic                 span_zero_reg;
    logic [NOW_W-1:0]     den_reg;
    logic [NOW_W-1:0]     lkd_reg;
    logic [NOW_W-1:0]     num;
    logic [NOW_W:0]       drem_reg;
    logic [NOW_W:0]       div_sh;
    logic                 rzero_reg;
    logic [FRAC_BITS-1:0] ratio_reg;
    logic [FRAC_BITS-1:0] r_eff;

    // blend
    logic signed [DIFF_W-1:0] diff0, diff1;
    logic signed [PROD_W-1:0] prod0_reg, prod1_reg;
    logic signed [DATA_W-1:0] res0, res1;
    logic signed [DATA_W-1:0] res_reg [5];

    assign dur_eff = (loop_duration == '0) ? DATA_W'(1) : loop_duration;
    assign smp_eff = (sample_count == '0) ? SMP_W'(1) : sample_count;

    // memory write port: clear pass or key write
    assign wr_addr     = cmd.clr_wr ? cmd.cnt[KEY_W-1:0] : key_index;
    assign wr_first    = (cmd.cnt == '0);
    assign pos_wr_data = cmd.clr_wr ? {wr_first, {(2 * DATA_W){1'b0}}}
                                    : {1'b1, value_first, value_second};
    assign rot_wr_data = cmd.clr_wr ? {wr_first, {DATA_W{1'b0}}}
                                    : {1'b1, value_first};
    assign scl_wr_data = cmd.clr_wr ? {wr_first, FIX_ONE, FIX_ONE}
                                    : {1'b1, value_first, value_second};

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr || (cmd.key_wr && op == OP_POS))
        begin
            pos_mem[wr_addr] <= pos_wr_data;
        end
        if (cmd.clr_wr || (cmd.key_wr && op == OP_ROT))
        begin
            rot_mem[wr_addr] <= rot_wr_data;
        end
        if (cmd.clr_wr || (cmd.key_wr && op == OP_SCL))
        begin
            scl_mem[wr_addr] <= scl_wr_data;
        end
        pos_rd_reg <= pos_mem[cmd.cnt[KEY_W-1:0]];
        rot_rd_reg <= rot_mem[cmd.cnt[KEY_W-1:0]];
        scl_rd_reg <= scl_mem[cmd.cnt[KEY_W-1:0]];
    end

    // split read words per track
    always_comb
    begin
        rd_vld[0] = pos_rd_reg[PAIR_W-1];
        rd_v0[0]  = pos_rd_reg[2*DATA_W-1:DATA_W];
        rd_v1[0]  = pos_rd_reg[DATA_W-1:0];
        rd_vld[1] = rot_rd_reg[ROT_W-1];
        rd_v0[1]  = rot_rd_reg[DATA_W-1:0];
        rd_v1[1]  = '0;
        rd_vld[2] = scl_rd_reg[PAIR_W-1];
        rd_v0[2]  = scl_rd_reg[2*DATA_W-1:DATA_W];
        rd_v1[2]  = scl_rd_reg[DATA_W-1:0];
    end

    // one restoring step of (clock + step) mod duration
    assign mod_sh = {rem_reg, sum_reg[SUM_W-1]};

    // hold the loop clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= '0;
        end
        else if (cmd.mul_now)
        begin
            clock_reg <= rem_reg;
        end
    end

    // wrap the clock, then scale it to sample units
    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            sum_reg <= SUM_W'(clock_reg) + SUM_W'(time_step);
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            sum_reg <= {sum_reg[SUM_W-2:0], 1'b0};
            if (mod_sh >= SUM_W'(dur_eff))
            begin
                rem_reg <= DATA_W'(mod_sh - SUM_W'(dur_eff));
            end
            else
            begin
                rem_reg <= mod_sh[DATA_W-1:0];
            end
        end
        if (cmd.mul_now)
        begin
            now_reg <= NOW_W'(rem_reg) * NOW_W'(smp_eff);
        end
    end

    assign scan_key = KEY_W'(cmd.cnt - 1'b1);

    // scan all keys of the three tracks in parallel
    always_ff @(posedge clk)
    begin
        if (cmd.mul_now)
        begin
            kd_reg <= '0;
            for (int t = 0; t < NUM_TRK; t++)
            begin
                found_reg[t] <= 1'b0;
                lk_reg[t]    <= '0;
                nk_reg[t]    <= '0;
            end
        end
        else if (cmd.scan_step && cmd.cnt != '0)
        begin
            kd_reg <= kd_reg + NOW_W'(dur_eff);
            for (int t = 0; t < NUM_TRK; t++)
            begin
                if (rd_vld[t] && !found_reg[t])
                begin
                    if (kd_reg <= now_reg)
                    begin
                        lk_reg[t] <= scan_key;
                        a0_reg[t] <= rd_v0[t];
                        a1_reg[t] <= rd_v1[t];
                        // key 0 is the target when no later key exists
                        if (scan_key == '0)
                        begin
                            b0_reg[t] <= rd_v0[t];
                            b1_reg[t] <= rd_v1[t];
                        end
                    end
                    else
                    begin
                        found_reg[t] <= 1'b1;
                        nk_reg[t]    <= scan_key;
                        b0_reg[t]    <= rd_v0[t];
                        b1_reg[t]    <= rd_v1[t];
                    end
                end
            end
        end
    end

    // span in keys; up to loop end when no later key
    always_comb
    begin
        if (found_reg[cmd.trk])
        begin
            span = SMP_W'(nk_reg[cmd.trk] - lk_reg[cmd.trk]);
        end
        else if (smp_eff > SMP_W'(lk_reg[cmd.trk]))
        begin
            span = smp_eff - SMP_W'(lk_reg[cmd.trk]);
        end
        else
        begin
            span = '0;
        end
    end

    assign num    = now_reg - lkd_reg;
    assign div_sh = {drem_reg[NOW_W-1:0], 1'b0};
    assign r_eff  = rzero_reg ? '0 : ratio_reg;

    // ratio = elapsed / span, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.track_setup)
        begin
            span_zero_reg <= (span == '0);
            den_reg       <= NOW_W'(span) * NOW_W'(dur_eff);
            lkd_reg       <= NOW_W'(lk_reg[cmd.trk]) * NOW_W'(dur_eff);
        end
        if (cmd.div_init)
        begin
            rzero_reg <= span_zero_reg || (num >= den_reg);
            drem_reg  <= (NOW_W + 1)'(num);
            ratio_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_sh >= (NOW_W + 1)'(den_reg))
            begin
                drem_reg  <= div_sh - (NOW_W + 1)'(den_reg);
                ratio_reg <= {ratio_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                drem_reg  <= div_sh;
                ratio_reg <= {ratio_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // blend: a + floor((b - a) * r / 2^FRAC_BITS)
    assign diff0 = DIFF_W'(b0_reg[cmd.trk]) - DIFF_W'(a0_reg[cmd.trk]);
    assign diff1 = DIFF_W'(b1_reg[cmd.trk]) - DIFF_W'(a1_reg[cmd.trk]);
    assign res0  = a0_reg[cmd.trk] + prod0_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign res1  = a1_reg[cmd.trk] + prod1_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_mul)
        begin
            prod0_reg <= PROD_W'(diff0) * PROD_W'($signed({1'b0, r_eff}));
            prod1_reg <= PROD_W'(diff1) * PROD_W'($signed({1'b0, r_eff}));
        end
        if (cmd.lerp_add)
        begin
            priority case (cmd.trk)
                TRK_POS:
                begin
                    res_reg[0] <= res0;
                    res_reg[1] <= res1;
                end
                TRK_ROT:
                begin
                    res_reg[2] <= res0;
                end
                default:
                begin
                    res_reg[3] <= res0;
                    res_reg[4] <= res1;
                end
            endcase
        end
        // drive the result register
        if (cmd.out_load)
        begin
            pos_x   <= res_reg[0];
            pos_y   <= res_reg[1];
            angle   <= res_reg[2];
            scale_x <= res_reg[3];
            scale_y <= res_reg[4];
        end
    end

endmodule

FILE: hdl/looping_keyframe_interpolator.sv
// Looping keyframe interpolator, top level: configuration registers and
// wiring of lki_ctrl and lki_dpath. Depends on lki_pkg.
//
// Usage:
//  - Request channel (item_valid / item_stall): op selects a tick (0) or a
//    key write for position (1), rotation (2) or scale (3).
//  - A key write is stored as it is accepted and gives no result.
//  - A tick advances the loop clock modulo loop_duration and yields one
//    result (pos_x, pos_y, angle, scale_x, scale_y) on the result channel
//    (result_valid / result_stall) after acceptance, by these steps: clock
//    wrap (one remainder bit a cycle), a multiply, key scan (one key of
//    every track a cycle from the key memories), ratio divide and blend
//    for each track, and a load of the output register.
//  - One tick is in flight at a time; the next request is taken once the
//    result is parked in the output register.
//  - Reset clears all three key maps in a pass over every key, one key a cycle,
//    during which item_stall stays high; configuration writes still work.
//  - While result_stall is high the result holds; a finished tick waits
//    for the output register to free before it is loaded.
//  - Registers: loop_duration at 0x0, sample_count at 0x4.
module looping_keyframe_interpolator
    import lki_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               op,
    input  logic [DATA_W-1:0]        time_step,
    input  logic [KEY_W-1:0]         key_index,
    input  logic signed [DATA_W-1:0] value_first,
    input  logic signed [DATA_W-1:0] value_second,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] pos_x,
    output logic signed [DATA_W-1:0] pos_y,
    output logic signed [DATA_W-1:0] angle,
    output logic signed [DATA_W-1:0] scale_x,
    output logic signed [DATA_W-1:0] scale_y
);

    localparam logic REG_DUR = 1'b0;
    localparam logic REG_SMP = 1'b1;

    logic [DATA_W-1:0] dur_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic              cfg_wr;
    lki_cmd_t          cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= 32'd65536;
            smp_reg <= 11'd60;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DUR)
            begin
                dur_reg <= pwdata;
            end
            else
            begin
                smp_reg <= pwdata[SMP_W-1:0];
            end
        end
    end

    // read back configuration
    assign prdata = (paddr[2] == REG_SMP) ? 32'(smp_reg) : dur_reg;

    lki_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .op           (op),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    lki_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .time_step     (time_step),
        .key_index     (key_index),
        .value_first   (value_first),
        .value_second  (value_second),
        .loop_duration (dur_reg),
        .sample_count  (smp_reg),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .angle         (angle),
        .scale_x       (scale_x),
        .scale_y       (scale_y)
    );

endmodule

FILE: tb/lki_checker.sv
// Checker for the looping keyframe interpolator: watches the request, result and
// register channels, predicts every tick result and compares. Depends on lki_pkg.
module lki_checker
    import lki_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    input  logic                     pready,
    input  logic                     item_valid,
    input  logic                     item_stall,
    input  logic [1:0]               op,
    input  logic [DATA_W-1:0]        time_step,
    input  logic [KEY_W-1:0]         key_index,
    input  logic signed [DATA_W-1:0] value_first,
    input  logic signed [DATA_W-1:0] value_second,
    input  logic                     result_valid,
    input  logic                     result_stall,
    input  logic signed [DATA_W-1:0] pos_x,
    input  logic signed [DATA_W-1:0] pos_y,
    input  logic signed [DATA_W-1:0] angle,
    input  logic signed [DATA_W-1:0] scale_x,
    input  logic signed [DATA_W-1:0] scale_y,
    output int                       fail_count,
    output int                       pending_count,
    output int                       result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] px, py, an, sx, sy;
    } pose_t;

    logic [31:0] duration_reg;
    logic [10:0] samples_reg;
    logic [31:0] clock_q;
    logic        valid_map [NUM_TRK][MAX_KEYS];
    logic [31:0] first_mem [NUM_TRK][MAX_KEYS];
    logic [31:0] second_mem[NUM_TRK][MAX_KEYS];
    pose_t       pose_queue[$];

    // Bracket keys for one track and the Q0.16 ratio between them.
    function automatic void bracket(input int t, input logic [31:0] dur,
                                    input logic [31:0] smp, output int lk,
                                    output int nk, output logic [31:0] r);
        logic [63:0] now, num, den, rem;
        int span;
        now = 64'(clock_q) * smp;
        lk = 0;
        nk = 0;
        r = 0;
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            if (valid_map[t][k])
            begin
                if (64'(k) * dur <= now)
                    lk = k;
                else
                begin
                    nk = k;
                    break;
                end
            end
        end
        if (nk != 0)
            span = nk - lk;
        else
            span = (int'(smp) > lk) ? int'(smp) - lk : 0;
        if (span == 0)
            return;
        den = 64'(span) * dur;
        num = now - 64'(lk) * dur;
        if (num >= den)
            return;
        rem = num;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            r = r << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                r[0] = 1'b1;
            end
        end
    endfunction

    // Blend a toward b, floor rounding.
    function automatic logic [31:0] blend(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic [31:0] r);
        longint diff, delta;
        logic [63:0] p;
        diff = longint'(b) - longint'(a);
        if (diff >= 0)
        begin
            p = 64'(diff) * r;
            delta = longint'(p >> FRAC_BITS);
        end
        else
        begin
            p = 64'(-diff) * r;
            delta = -longint'((p + 64'(2**FRAC_BITS - 1)) >> FRAC_BITS);
        end
        return 32'(longint'(a) + delta);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        duration_reg = 32'd65536;
        samples_reg = 11'd60;
        clock_q = 0;
        for (int t = 0; t < NUM_TRK; t++)
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                valid_map[t][k] = (k == 0);
                first_mem[t][k] = (t == 2 && k == 0) ? FIX_ONE : 32'd0;
                second_mem[t][k] = (t == 2 && k == 0) ? FIX_ONE : 32'd0;
            end
    end

    // Track registers, requests and results.
    always @(posedge clk)
    begin
        logic [31:0] dur, smp, r;
        int lk, nk, t;
        pose_t e, g;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_DURATION)
                    duration_reg = pwdata;
                else if (paddr == ADDR_SAMPLES)
                    samples_reg = pwdata[10:0];
            end
            if (item_valid && !item_stall)
            begin
                if (op == OP_TICK)
                begin
                    dur = (duration_reg == 0) ? 32'd1 : duration_reg;
                    smp = (samples_reg == 0) ? 32'd1 : 32'(samples_reg);
                    clock_q = 32'((64'(clock_q) + time_step) % dur);
                    bracket(0, dur, smp, lk, nk, r);
                    e.px = blend(first_mem[0][lk], first_mem[0][nk], r);
                    e.py = blend(second_mem[0][lk], second_mem[0][nk], r);
                    bracket(1, dur, smp, lk, nk, r);
                    e.an = blend(first_mem[1][lk], first_mem[1][nk], r);
                    bracket(2, dur, smp, lk, nk, r);
                    e.sx = blend(first_mem[2][lk], first_mem[2][nk], r);
                    e.sy = blend(second_mem[2][lk], second_mem[2][nk], r);
                    pose_queue.push_back(e);
                end
                else
                begin
                    t = (op == OP_POS) ? 0 : (op == OP_ROT) ? 1 : 2;
                    valid_map[t][key_index] = 1'b1;
                    first_mem[t][key_index] = value_first;
                    if (op != OP_ROT)
                        second_mem[t][key_index] = value_second;
                end
            end
            if (result_valid && !result_stall)
            begin
                result_count++;
                if (pose_queue.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    e = pose_queue.pop_front();
                    g = {pos_x, pos_y, angle, scale_x, scale_y};
                    if (g.px !== e.px) report("pos_x", g.px, e.px);
                    if (g.py !== e.py) report("pos_y", g.py, e.py);
                    if (g.an !== e.an) report("angle", g.an, e.an);
                    if (g.sx !== e.sx) report("scale_x", g.sx, e.sx);
                    if (g.sy !== e.sy) report("scale_y", g.sy, e.sy);
                end
            end
            pending_count = pose_queue.size();
        end
    end
endmodule

FILE: tb/looping_keyframe_interpolator_test.sv
// Top of the looping keyframe interpolator testbench: clock, reset, register
// writes and request stimulus; verdict from lki_checker. Depends on lki_pkg.
module looping_keyframe_interpolator_test;
    import lki_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 60000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic item_valid = 0;
    logic item_stall;
    logic [1:0] op = 0;
    logic [DATA_W-1:0] time_step = 0;
    logic [KEY_W-1:0] key_index = 0;
    logic signed [DATA_W-1:0] value_first = 0, value_second = 0;
    logic result_valid;
    logic result_stall = 1'b1;
    logic signed [DATA_W-1:0] pos_x, pos_y, angle, scale_x, scale_y;
    int fail_count, pending_count, result_count;
    int idle_cycles = 0;
    int request_count = 0;
    bit hold_results = 0;

    looping_keyframe_interpolator dut (.*);

    lki_checker checker_i (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: end on a long stretch with no accepted request or result.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d results pending", pending_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stall per result, plus one long hold-off.
    initial
    begin
        int w;
        @(negedge clk);
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_stall = 1'b1;
                repeat (4000) @(negedge clk);
                hold_results = 0;
                result_stall = 1'b0;
            end
            if (result_valid && !result_stall)
            begin
                w = $urandom_range(0, 10);
                result_stall = (w != 0);
                repeat (w) @(negedge clk);
                result_stall = 1'b0;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    // Offer one request and hold it until accepted.
    task automatic send(input op_t o, input logic [31:0] ts, input logic [9:0] k,
                        input logic [31:0] a, input logic [31:0] b, input bit gaps);
        if (gaps)
            repeat ($urandom_range(0, 10)) @(negedge clk);
        op = o;
        time_step = ts;
        key_index = k;
        value_first = a;
        value_second = b;
        item_valid = 1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        item_valid = 0;
        request_count++;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    task automatic random_phase(input int n, input int max_key);
        int c;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(0, 9);
            if (c < 4)
                send(OP_TICK, (c == 0) ? $urandom : $urandom_range(0, 32'h4000),
                     0, 0, 0, 1);
            else
                send(op_t'($urandom_range(1, 3)), $urandom,
                     10'($urandom_range(0, max_key)), $urandom, $urandom, 1);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset map, extremes, every op, wrap and ignored value_second.
        send(OP_TICK, 32'd0, 0, 0, 0, 0);
        send(OP_TICK, 32'd32768, 0, 0, 0, 0);
        send(OP_POS, 0, 10'd0, 32'h8000_0000, 32'h7fff_ffff, 0);
        send(OP_POS, 0, 10'd30, 32'h7fff_ffff, 32'h8000_0000, 0);
        send(OP_ROT, 0, 10'd15, 32'h0001_0000, 32'hffff_ffff, 0);
        send(OP_SCL, 0, 10'd45, 32'hffff_0000, 32'h0003_0000, 0);
        send(OP_SCL, 0, 10'd1023, 32'h1234_5678, 32'h8765_4321, 0);
        send(OP_TICK, 32'd16384, 0, 0, 0, 0);
        send(OP_TICK, 32'd20000, 0, 0, 0, 0);
        send(OP_TICK, 32'hffff_ffff, 0, 0, 0, 0);
        send(OP_TICK, 32'd65535, 0, 0, 0, 0);
        drain();
        // Zero duration and zero samples degenerate to one.
        reg_write(ADDR_DURATION, 32'd0);
        reg_write(ADDR_SAMPLES, 32'd0);
        send(OP_TICK, 32'd5, 0, 0, 0, 0);
        send(OP_POS, 0, 10'd1, 32'd100, 32'd200, 0);
        send(OP_TICK, 32'd7, 0, 0, 0, 0);
        drain();
        // Maximum duration and sample count 1024; clock reduced at next tick.
        reg_write(ADDR_DURATION, 32'hffff_ffff);
        reg_write(ADDR_SAMPLES, 32'd1024);
        send(OP_TICK, 32'h8000_0000, 0, 0, 0, 0);
        send(OP_TICK, 32'h7fff_ffff, 0, 0, 0, 0);
        send(OP_TICK, 32'hffff_fffe, 0, 0, 0, 0);
        drain();

        // Random phases across several settings.
        reg_write(ADDR_DURATION, 32'h0004_0000);
        reg_write(ADDR_SAMPLES, 32'd16);
        random_phase(70, 20);
        drain();
        reg_write(ADDR_DURATION, 32'd1);
        reg_write(ADDR_SAMPLES, 32'd1);
        random_phase(30, 3);
        drain();
        reg_write(ADDR_DURATION, $urandom);
        reg_write(ADDR_SAMPLES, 11'($urandom_range(1, 1024)));
        random_phase(70, 1023);
        drain();

        // Pressure: receiver holds off while ticks keep coming.
        reg_write(ADDR_DURATION, 32'd65536);
        reg_write(ADDR_SAMPLES, 32'd60);
        hold_results = 1;
        for (int i = 0; i < 5; i++)
            send(OP_TICK, $urandom_range(0, 32'h8000), 0, 0, 0, 0);
        // Pause until every result is back, then go on.
        while (pending_count != 0)
            @(negedge clk);
        random_phase(90, 100);
        drain();

        $display("covered %0d requests, %0d results, six register settings",
                 request_count, result_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
